[rtl/arps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arps_pkg: shared types and constants
// Widths, register indexes and the square-root step of the ring shader.
// ----------------------------------------------------------------------------
package arps_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int OFS_W      = 11;
  localparam int CRD_W      = 12;
  localparam int RAD_CFG_W  = 10;
  localparam int PT_W       = 14;
  localparam int SUM_W      = 23;
  localparam int ROOT_W     = 20;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQ_STAGES  = ROOT_W / 2;
  localparam int T_W        = FRAC_BITS + 1;
  localparam int PROD_W     = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_THICKNESS = 3'd3,
    CFG_FILLED    = 3'd4,
    CFG_FILL_COL  = 3'd5,
    CFG_OUTL_COL  = 3'd6
  } cfg_idx_e;

  // Offset carried alongside the arithmetic
  typedef struct packed {
    logic [OFS_W-1:0] x;
    logic [OFS_W-1:0] y;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  // One restoring digit of the square root
  function automatic sq_state_t sq_step(sq_state_t s, logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_state_t        r;
    cur   = {s.rem[REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/arps_sqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arps_sqrt: pipelined integer square root
// Two result bits per stage, ten stages, offset tag travels with the data.
// ----------------------------------------------------------------------------
module arps_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [arps_pkg::RAD_W-1:0]  rad_i,
  input  wire arps_pkg::tag_t              tag_i,
  output logic                             valid_o,
  output logic [arps_pkg::ROOT_W-1:0]      root_o,
  output arps_pkg::tag_t                   tag_o
);
  import arps_pkg::*;

  sq_state_t          st_q  [SQ_STAGES];
  logic [RAD_W-1:0]   rad_q [SQ_STAGES];
  tag_t               tag_q [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_q;

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_stage
    sq_state_t        st_in, st_mid, st_out;
    logic [RAD_W-1:0] rad_in;
    tag_t             tag_in;
    logic             vld_in;

    if (i == 0) begin : g_first
      assign st_in  = '0;
      assign rad_in = rad_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign st_in  = st_q[i-1];
      assign rad_in = rad_q[i-1];
      assign tag_in = tag_q[i-1];
      assign vld_in = vld_q[i-1];
    end

    // two digits per stage
    always_comb begin
      st_mid = sq_step(st_in, rad_in[RAD_W-1 -: 2]);
      st_out = sq_step(st_mid, rad_in[RAD_W-3 -: 2]);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i]  <= st_out;
        rad_q[i] <= {rad_in[RAD_W-5:0], 4'b0000};
        tag_q[i] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign root_o  = st_q[SQ_STAGES-1].root;
  assign tag_o   = tag_q[SQ_STAGES-1];

endmodule
`default_nettype wire

[rtl/arps_shade.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arps_shade: band classification and colour blend products
// Stage 1 picks the band, colours and blend factor; stage 2 forms products.
// ----------------------------------------------------------------------------
module arps_shade (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic [arps_pkg::ROOT_W-1:0]     dist_i,
  input  wire arps_pkg::tag_t                  tag_i,
  input  wire logic [arps_pkg::RAD_CFG_W-1:0]  radius_i,
  input  wire logic [arps_pkg::RAD_CFG_W-1:0]  thickness_i,
  input  wire logic                            filled_i,
  input  wire logic [31:0]                     fill_color_i,
  input  wire logic [31:0]                     outline_color_i,
  output logic                                 valid_o,
  output arps_pkg::tag_t                       tag_o,
  output logic [3:0][7:0]                      base_o,
  output logic [3:0][arps_pkg::PROD_W-1:0]     prod_o
);
  import arps_pkg::*;

  localparam int CMP_W = ROOT_W + 2;
  localparam logic signed [CMP_W-1:0] HALF = CMP_W'(1 << (FRAC_BITS - 1));
  localparam logic [T_W-1:0]          ONE  = T_W'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    BAND_FILL, BAND_INNER, BAND_RING, BAND_FADE, BAND_NONE
  } band_e;

  // Blend factor clamped to [0, ONE]
  function automatic logic [T_W-1:0] clamp_t(logic signed [CMP_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(CMP_W-T_W){1'b0}}, ONE})) begin
      return ONE;
    end else begin
      return v[T_W-1:0];
    end
  endfunction

  // ---- classification ----
  logic signed [RAD_CFG_W:0] rin_w;
  logic signed [CMP_W-1:0]   d_s, rin_s, rout_s;
  logic signed [CMP_W-1:0]   lo_in, hi_in, lo_out, hi_out;
  logic [31:0]               under_col;
  band_e                     band;
  logic [31:0]               c1_d, c2_d;
  logic [T_W-1:0]            t_d;

  always_comb begin
    rin_w     = $signed({1'b0, radius_i}) - $signed({1'b0, thickness_i});
    d_s       = $signed({2'b00, dist_i});
    rin_s     = CMP_W'($signed({rin_w, {FRAC_BITS{1'b0}}}));
    rout_s    = $signed({{(CMP_W-RAD_CFG_W-FRAC_BITS){1'b0}}, radius_i,
                         {FRAC_BITS{1'b0}}});
    lo_in     = rin_s - HALF;
    hi_in     = rin_s + HALF;
    lo_out    = rout_s - HALF;
    hi_out    = rout_s + HALF;
    under_col = filled_i ? fill_color_i : 32'h0;

    if (d_s <= lo_in) begin
      band = BAND_FILL;
    end else if (d_s < hi_in) begin
      band = BAND_INNER;
    end else if (d_s <= lo_out) begin
      band = BAND_RING;
    end else if (d_s < hi_out) begin
      band = BAND_FADE;
    end else begin
      band = BAND_NONE;
    end

    case (band)
      BAND_FILL: begin
        c1_d = under_col;       c2_d = under_col;     t_d = '0;
      end
      BAND_INNER: begin
        c1_d = under_col;       c2_d = outline_color_i;
        t_d  = clamp_t(d_s - lo_in);
      end
      BAND_RING: begin
        c1_d = outline_color_i; c2_d = outline_color_i; t_d = '0;
      end
      BAND_FADE: begin
        // colour kept, alpha ramps from zero
        c1_d = {outline_color_i[31:8], 8'h00}; c2_d = outline_color_i;
        t_d  = clamp_t(hi_out - d_s);
      end
      default: begin
        c1_d = '0;              c2_d = '0;            t_d = '0;
      end
    endcase
  end

  logic           v1_q;
  tag_t           tag1_q;
  logic [31:0]    c1_q, c2_q;
  logic [T_W-1:0] t_q;

  // ---- blend products ----
  logic [3:0][PROD_W-1:0] prod_d;
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      prod_d[ch] = PROD_W'($signed({1'b0, t_q}) *
                   ($signed({1'b0, c2_q[8*ch +: 8]}) - $signed({1'b0, c1_q[8*ch +: 8]})));
    end
  end

  logic v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag1_q <= tag_i;
      c1_q   <= c1_d;
      c2_q   <= c2_d;
      t_q    <= t_d;
      tag_o  <= tag1_q;
      base_o <= c1_q;
      prod_o <= prod_d;
    end
  end

  assign valid_o = v2_q;

endmodule
`default_nettype wire

[rtl/arps_emit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arps_emit: colour finish and mirrored point emission
// Holds an offset; sends its up to four mirrored points, one per unstalled cycle.
// ----------------------------------------------------------------------------
module arps_emit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire arps_pkg::tag_t                  tag_i,
  input  wire logic [3:0][7:0]                 base_i,
  input  wire logic [3:0][arps_pkg::PROD_W-1:0] prod_i,
  input  wire logic [arps_pkg::CRD_W-1:0]      center_x_i,
  input  wire logic [arps_pkg::CRD_W-1:0]      center_y_i,
  output logic                                 en_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [arps_pkg::PT_W-1:0]     point_x_o,
  output logic signed [arps_pkg::PT_W-1:0]     point_y_o,
  output logic [7:0]                           red_o,
  output logic [7:0]                           green_o,
  output logic [7:0]                           blue_o,
  output logic [7:0]                           alpha_o,
  output logic                                 last_o
);
  import arps_pkg::*;

  logic [3:0]      pend_q, pend_d;
  logic [3:0]      cur;
  logic [31:0]     col_q, col_d;
  logic [PT_W-1:0] xp_q, xn_q, yp_q, yn_q;
  logic            fire, load;

  // Finish channels: base*ONE + product, then drop fraction
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      col_d[8*ch +: 8] = 8'(($signed({2'b00, base_i[ch], {FRAC_BITS{1'b0}}}) +
                          $signed(prod_i[ch])) >>> FRAC_BITS);
    end
  end

  // Lowest pending point goes first
  always_comb begin
    cur = pend_q & (~pend_q + 4'd1);
  end

  assign out_valid_o = |pend_q;
  assign last_o      = ((pend_q & ~cur) == 4'b0000);
  assign fire        = out_valid_o && !out_stall_i;
  assign en_o        = !out_valid_o || (fire && last_o);
  assign load        = en_o && valid_i && (col_d[7:0] != 8'h00);

  always_comb begin
    pend_d = pend_q;
    if (fire) begin
      pend_d = pend_q & ~cur;
    end
    if (load) begin
      pend_d = {(tag_i.x != '0) && (tag_i.y != '0), tag_i.y != '0, tag_i.x != '0, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Coordinates and colour for the held offset
  always_ff @(posedge clk_i) begin
    if (load) begin
      col_q <= col_d;
      xp_q  <= {2'b00, center_x_i} + {3'b000, tag_i.x};
      xn_q  <= {2'b00, center_x_i} - {3'b000, tag_i.x};
      yp_q  <= {2'b00, center_y_i} + {3'b000, tag_i.y};
      yn_q  <= {2'b00, center_y_i} - {3'b000, tag_i.y};
    end
  end

  assign point_x_o = (cur[1] || cur[3]) ? xn_q : xp_q;
  assign point_y_o = (cur[2] || cur[3]) ? yn_q : yp_q;
  assign red_o     = col_q[31:24];
  assign green_o   = col_q[23:16];
  assign blue_o    = col_q[15:8];
  assign alpha_o   = col_q[7:0];

endmodule
`default_nettype wire

[rtl/antialiased_ring_pixel_shader_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// antialiased_ring_pixel_shader_core: antialiased ring pixel shader
// Shades one quadrant offset and emits its mirrored, coloured points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries one offset (x, y) per
//   transaction. Output channel out_valid_o / out_stall_i carries one point
//   per transaction; last_o marks the final point of an offset.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; unknown indexes are ignored.
//   Throughput: the pipeline takes one offset per cycle when not stalled; the
//   emitter sends one point per cycle when out_stall_i is low, so an offset
//   yielding N points (1 to 4) takes N output transactions. Offsets with zero
//   alpha emit no point and take no output transaction.
//   The path is a 2-stage square/sum, a 10-stage square root (two result bits
//   per stage), classification, blend product and the point emitter.
//   Reset clears all valid bits and loads register defaults (thickness 1).
//   When the receiver stalls a pending point the whole pipeline holds; in_stall_o
//   is high while the emitter holds points, except in the cycle its last one leaves.
// ----------------------------------------------------------------------------
module antialiased_ring_pixel_shader_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [arps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [arps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [arps_pkg::OFS_W-1:0]        offset_x_i,
  input  wire logic [arps_pkg::OFS_W-1:0]        offset_y_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [arps_pkg::PT_W-1:0]       point_x_o,
  output logic signed [arps_pkg::PT_W-1:0]       point_y_o,
  output logic [7:0]                             red_o,
  output logic [7:0]                             green_o,
  output logic [7:0]                             blue_o,
  output logic [7:0]                             alpha_o,
  output logic                                   last_o
);
  import arps_pkg::*;

  // ---- configuration registers ----
  logic [CRD_W-1:0]     center_x_q, center_y_q;
  logic [RAD_CFG_W-1:0] radius_q, thickness_q;
  logic                 filled_q;
  logic [31:0]          fill_col_q, outl_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      radius_q    <= '0;
      thickness_q <= RAD_CFG_W'(1);
      filled_q    <= 1'b0;
      fill_col_q  <= '0;
      outl_col_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:  center_x_q  <= cfg_data_i[CRD_W-1:0];
        CFG_CENTER_Y:  center_y_q  <= cfg_data_i[CRD_W-1:0];
        CFG_RADIUS:    radius_q    <= cfg_data_i[RAD_CFG_W-1:0];
        CFG_THICKNESS: thickness_q <= cfg_data_i[RAD_CFG_W-1:0];
        CFG_FILLED:    filled_q    <= cfg_data_i[0];
        CFG_FILL_COL:  fill_col_q  <= cfg_data_i;
        CFG_OUTL_COL:  outl_col_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  assign in_stall_o = !en;

  // ---- squares, then their sum ----
  logic                    va_q, vb_q;
  logic [2*OFS_W-1:0]      xx_q, yy_q;
  logic [SUM_W-1:0]        sum_q;
  tag_t                    taga_q, tagb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q   <= offset_x_i * offset_x_i;
      yy_q   <= offset_y_i * offset_y_i;
      taga_q <= '{x: offset_x_i, y: offset_y_i};
      sum_q  <= {1'b0, xx_q} + {1'b0, yy_q};
      tagb_q <= taga_q;
    end
  end

  // ---- distance ----
  logic              sq_v;
  logic [ROOT_W-1:0] sq_dist;
  tag_t              sq_tag;

  arps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb_q),
    .rad_i   ({{(RAD_W-SUM_W-2*FRAC_BITS){1'b0}}, sum_q, {(2*FRAC_BITS){1'b0}}}),
    .tag_i   (tagb_q),
    .valid_o (sq_v),
    .root_o  (sq_dist),
    .tag_o   (sq_tag)
  );

  // ---- shading ----
  logic                   sh_v;
  tag_t                   sh_tag;
  logic [3:0][7:0]        sh_base;
  logic [3:0][PROD_W-1:0] sh_prod;

  arps_shade u_shade (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .valid_i         (sq_v),
    .dist_i          (sq_dist),
    .tag_i           (sq_tag),
    .radius_i        (radius_q),
    .thickness_i     (thickness_q),
    .filled_i        (filled_q),
    .fill_color_i    (fill_col_q),
    .outline_color_i (outl_col_q),
    .valid_o         (sh_v),
    .tag_o           (sh_tag),
    .base_o          (sh_base),
    .prod_o          (sh_prod)
  );

  // ---- emission ----
  arps_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (sh_v),
    .tag_i       (sh_tag),
    .base_i      (sh_base),
    .prod_i      (sh_prod),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .point_x_o   (point_x_o),
    .point_y_o   (point_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  // idle output never blocks the input
  a_idle_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o) else $error("stall while output idle");

  // a point that is not last is followed by another
  a_more_points : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("points lost after non-last point");

  // points are never emitted with zero alpha
  a_alpha_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alpha_o != 8'h00) else $error("transparent point emitted");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ring shader point checker
// Drives offsets through several register settings and idling patterns, and
// compares every emitted point with a local prediction of distance banding,
// colour blending and quadrant mirroring.
// ----------------------------------------------------------------------------

// Expected point and the queue of points still owed by the block
typedef struct {
  logic signed [13:0] px;
  logic signed [13:0] py;
  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;
  logic [7:0]         a;
  logic               lst;
} ring_point_t;

class ring_scoreboard;
  // Register copy
  int unsigned cx, cy, rad, thick, fill_on, fill_col, outl_col;
  ring_point_t owed[$];
  int          errors;

  function void reset_regs();
    cx = 0; cy = 0; rad = 0; thick = 1; fill_on = 0; fill_col = 0; outl_col = 0;
  endfunction

  function void write_reg(arps_pkg::cfg_idx_e idx, logic [31:0] val);
    case (idx)
      arps_pkg::CFG_CENTER_X:  cx = val[11:0];
      arps_pkg::CFG_CENTER_Y:  cy = val[11:0];
      arps_pkg::CFG_RADIUS:    rad = val[9:0];
      arps_pkg::CFG_THICKNESS: thick = val[9:0];
      arps_pkg::CFG_FILLED:    fill_on = val[0];
      arps_pkg::CFG_FILL_COL:  fill_col = val;
      arps_pkg::CFG_OUTL_COL:  outl_col = val;
      default: ;
    endcase
  endfunction

  // Integer square root by bisection on a 64-bit value
  function longint root_of(longint v);
    longint lo, hi, mid;
    lo = 0; hi = 64'd4194304;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid; else hi = mid - 1;
    end
    return lo;
  endfunction

  // Per-channel linear mix, blend factor in Q1.8
  function logic [31:0] mix(logic [31:0] c1, logic [31:0] c2, longint t);
    logic [31:0] res;
    longint ca, cb, s;
    if (t < 0) t = 0;
    if (t > 256) t = 256;
    for (int ch = 0; ch < 4; ch++) begin
      ca = (c1 >> (24 - 8 * ch)) & 8'hFF;
      cb = (c2 >> (24 - 8 * ch)) & 8'hFF;
      s  = ca * 256 + t * (cb - ca);
      res[31 - 8 * ch -: 8] = s[15:8];
    end
    return res;
  endfunction

  function void push_point(longint px, longint py, logic [31:0] col);
    ring_point_t p;
    p.px = px[13:0]; p.py = py[13:0];
    p.r = col[31:24]; p.g = col[23:16]; p.b = col[15:8]; p.a = col[7:0];
    p.lst = 1'b0;
    owed = {owed, p};
  endfunction

  // Note an accepted offset and queue the points it should produce
  function void note_offset(int unsigned x, int unsigned y);
    longint r_out, r_in, d, t, al;
    logic [31:0] col;
    r_out = longint'(rad) * 256;
    r_in  = (longint'(rad) - longint'(thick)) * 256;
    d     = root_of((longint'(x) * x + longint'(y) * y) << 16);
    col   = 0;
    if (d <= r_in - 128) begin
      if (fill_on != 0) col = fill_col;
    end else if (d < r_in + 128) begin
      col = mix((fill_on != 0) ? fill_col : 0, outl_col, d - (r_in - 128));
    end else if (d <= r_out - 128) begin
      col = outl_col;
    end else if (d < r_out + 128) begin
      t = r_out + 128 - d;
      if (t > 256) t = 256;
      if (t < 0) t = 0;
      al = (longint'(outl_col[7:0]) * t) >> 8;
      col = {outl_col[31:8], al[7:0]};
    end
    if (col[7:0] == 0) return;
    push_point(cx + x, cy + y, col);
    if (x != 0) push_point(longint'(cx) - x, cy + y, col);
    if (y != 0) push_point(cx + x, longint'(cy) - y, col);
    if (x != 0 && y != 0) push_point(longint'(cx) - x, longint'(cy) - y, col);
    owed[$].lst = 1'b1;
  endfunction

  function void check_point(ring_point_t got);
    ring_point_t e;
    if (owed.size() == 0) begin
      $error("unexpected point x=%0d y=%0d", got.px, got.py);
      errors++;
      return;
    end
    e = owed.pop_front();
    if (got.px !== e.px) begin
      $error("point_x expected %0d actual %0d", e.px, got.px); errors++;
    end
    if (got.py !== e.py) begin
      $error("point_y expected %0d actual %0d", e.py, got.py); errors++;
    end
    if (got.r !== e.r) begin
      $error("red expected %0d actual %0d", e.r, got.r); errors++;
    end
    if (got.g !== e.g) begin
      $error("green expected %0d actual %0d", e.g, got.g); errors++;
    end
    if (got.b !== e.b) begin
      $error("blue expected %0d actual %0d", e.b, got.b); errors++;
    end
    if (got.a !== e.a) begin
      $error("alpha expected %0d actual %0d", e.a, got.a); errors++;
    end
    if (got.lst !== e.lst) begin
      $error("last expected %0d actual %0d", e.lst, got.lst); errors++;
    end
  endfunction
endclass

module testbench;
  import arps_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OFS_W-1:0]      offset_x_i = '0;
  logic [OFS_W-1:0]      offset_y_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [PT_W-1:0] point_x_o, point_y_o;
  logic [7:0]            red_o, green_o, blue_o, alpha_o;
  logic                  last_o;

  ring_scoreboard sb;
  int             send_idle_pct = 0;
  int             stall_pct = 0;

  always #10 clk_i = ~clk_i;

  antialiased_ring_pixel_shader_core i_dut (.*);

  // Output side: random stalls, compare on each accepted point
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    ring_point_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.px = point_x_o; got.py = point_y_o;
      got.r = red_o; got.g = green_o; got.b = blue_o; got.a = alpha_o;
      got.lst = last_o;
      sb.check_point(got);
    end
  end

  // Register write while idle
  task automatic write_cfg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One offset transaction, with a random gap ahead of it; valid stays up
  // after acceptance so that the next transaction can follow directly
  task automatic send_offset(int unsigned x, int unsigned y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; offset_x_i <= x; offset_y_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_offset(x, y);
  endtask

  // Drop valid, wait until all points are out, then let the pipeline drain
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Offsets biased toward the ring bands of the current radius
  task automatic random_offsets(int n);
    int unsigned x, y, r, ang;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        x = $urandom_range(1024); y = $urandom_range(1024);
      end else begin
        r = sb.rad + $urandom_range(3);
        r = (r > 2) ? r - 2 : r;
        ang = $urandom_range(r);
        x = ang;
        y = (r * r > x * x) ? $rtoi($sqrt(real'(r * r - x * x))) : 0;
        if ($urandom_range(1)) begin x = y; y = ang; end
        if (x > 1024) x = 1024;
        if (y > 1024) y = 1024;
      end
      send_offset(x, y);
    end
  endtask

  task automatic set_ring(int unsigned c_x, int unsigned c_y, int unsigned rd,
                          int unsigned th, int unsigned fl,
                          logic [31:0] fc, logic [31:0] oc);
    write_cfg(CFG_CENTER_X, c_x);
    write_cfg(CFG_CENTER_Y, c_y);
    write_cfg(CFG_RADIUS, rd);
    write_cfg(CFG_THICKNESS, th);
    write_cfg(CFG_FILLED, fl);
    write_cfg(CFG_FILL_COL, fc);
    write_cfg(CFG_OUTL_COL, oc);
  endtask

  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset registers (nothing visible), then a small filled ring
    send_offset(0, 0);
    send_offset(1024, 1024);
    drain();
    set_ring(100, 200, 5, 2, 1, 32'hFF80_40FF, 32'h10E0_F0C0);
    send_offset(0, 0);
    send_offset(3, 0);
    send_offset(0, 3);
    send_offset(2, 2);
    send_offset(3, 2);
    send_offset(4, 3);
    send_offset(5, 0);
    send_offset(4, 4);
    send_offset(1024, 0);
    send_offset(0, 1024);
    send_offset(2047, 2047);
    drain();
    // Extremes: corner centres, radius max, thickness beyond radius
    set_ring(0, 0, 1023, 1023, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_offset(1024, 0);
    send_offset(723, 723);
    send_offset(1023, 1);
    send_offset(0, 1022);
    drain();
    set_ring(4095, 4095, 3, 10, 1, 32'h0, 32'hAA55_AA55);
    send_offset(0, 0);
    send_offset(2, 2);
    send_offset(3, 0);
    send_offset(1, 1);
    drain();

    // Random phases across settings and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      set_ring($urandom_range(4095), $urandom_range(4095),
               (ph == 7) ? 1023 : $urandom_range(60), $urandom_range(ph == 5 ? 1023 : 12),
               $urandom_range(1), $urandom(), $urandom());
      random_offsets(56);
      drain();
    end
    stall_pct = 0;
    repeat (30) @(posedge clk_i);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
